// File: rtl/pid_trapezoid_clamped_assert.svh
// ----------------------------------------------------------------------------
// PID assertion macros
// Concurrent assertion shorthands shared by the PID controller RTL.
// ----------------------------------------------------------------------------
`ifndef PID_TRAPEZOID_CLAMPED_ASSERT_SVH
`define PID_TRAPEZOID_CLAMPED_ASSERT_SVH

// Same-cycle implication.
`define PIDTC_ASSERT_IMP(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("pidtc assertion failed");

// Next-cycle implication.
`define PIDTC_ASSERT_NXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("pidtc assertion failed");

`endif

// File: rtl/pidtc_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Types, widths and helper functions for the trapezoidal PID controller.
// ----------------------------------------------------------------------------
package pidtc_pkg;

  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 48;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int DIV_N_W = 64;
  localparam int DIV_D_W = 32;

  typedef enum logic [2:0] {
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_UPPER,
    REG_LOWER
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_PMUL, S_PWAIT,
    S_TMUL, S_TWAIT,
    S_HDIV, S_HWAIT,
    S_LDIV, S_LWAIT,
    S_IMUL, S_IWAIT,
    S_DMUL, S_DWAIT,
    S_DDIV, S_DDWAIT,
    S_SUM, S_OUT
  } state_t;

  function automatic logic signed [65:0] with_sign(input logic neg, input logic [63:0] m);
    logic signed [65:0] v;
    v = $signed({2'b00, m});
    return neg ? -v : v;
  endfunction

  function automatic logic signed [31:0] clamp_term(input logic signed [65:0] v,
                                                    input logic signed [31:0] upper,
                                                    input logic signed [31:0] lower);
    logic signed [31:0] r;
    if (v > 66'(upper)) r = upper;
    else if (v < 66'(lower)) r = lower;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh7FFFFFFF) r = 32'sh7FFFFFFF;
    else if (v < -66'sh80000000) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

// File: rtl/pidtc_if.sv
// ----------------------------------------------------------------------------
// PID channel interfaces
// Valid/ready channels for samples in and results out.
// ----------------------------------------------------------------------------
interface pidtc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] setpoint;
  logic signed [31:0] measured;
  logic        [31:0] timestamp;
  modport source (output valid, setpoint, measured, timestamp, input ready);
  modport sink   (input valid, setpoint, measured, timestamp, output ready);
endinterface

interface pidtc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] command;
  logic signed [31:0] p_term;
  logic signed [31:0] i_term;
  logic signed [31:0] d_term;
  logic               ts_reject;
  modport source (output valid, command, p_term, i_term, d_term, ts_reject, input ready);
  modport sink   (input valid, command, p_term, i_term, d_term, ts_reject, output ready);
endinterface

// File: rtl/pidtc_mul.sv
// ----------------------------------------------------------------------------
// PID serial multiplier
// Unsigned shift-add multiplier that retires one multiplier bit per cycle
// and stops as soon as the remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module pidtc_mul
  import pidtc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] prod,
  output logic               done
);

  logic [MUL_P_W-1:0] a_sh;
  logic [MUL_B_W-1:0] b_sh;
  logic               busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && b_sh == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh <= MUL_P_W'(a);
      b_sh <= b;
      prod <= '0;
    end else if (busy && b_sh != '0) begin
      if (b_sh[0]) prod <= prod + a_sh;
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

endmodule

// File: rtl/pidtc_div.sv
// ----------------------------------------------------------------------------
// PID serial divider
// Unsigned restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidtc_div
  import pidtc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] num,
  input  logic [DIV_D_W-1:0] den,
  output logic [DIV_N_W-1:0] quo,
  output logic               done
);

  localparam int CNT_W = $clog2(DIV_N_W);

  logic [DIV_D_W-1:0] rem;
  logic [DIV_D_W-1:0] den_r;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [DIV_D_W:0]   rem_sh;
  logic               take;

  assign rem_sh = {rem, quo[DIV_N_W-1]};
  assign take   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(DIV_N_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
      cnt   <= '0;
    end else if (busy) begin
      rem <= take ? DIV_D_W'(rem_sh - {1'b0, den_r}) : rem_sh[DIV_D_W-1:0];
      quo <= {quo[DIV_N_W-2:0], take};
      cnt <= cnt + 1'b1;
    end
  end

endmodule

// File: rtl/pid_trapezoid_clamped.sv
// ----------------------------------------------------------------------------
// PID controller, trapezoidal integral with clamping
// Q16.16 PID step with anti-windup integral and rate-scaled derivative,
// sequenced over a shared serial multiplier and a shared serial divider.
// ----------------------------------------------------------------------------
//   channel   dir  beat
//   sample    in   setpoint, measured, timestamp
//   result    out  command, p_term, i_term, d_term, ts_reject
//   cfg       in   write_en, write_index, write_data (no handshake)
//
// A good sample runs the P multiply, the trapezoid multiply, both limit
// divides, the I and D multiplies and the D divide; a zero integral gain
// skips the trapezoid, limit and I steps. A division has 64 steps and a
// multiply one per significant bit. A bad-timestamp sample skips to S_SUM.
// One sample is worked at a time; the result register frees the core so the
// next sample is taken while a result waits, and a second result then stalls
// in the output state until the first beat leaves. Reset is synchronous.
module pid_trapezoid_clamped
  import pidtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        write_en,
  input  logic [2:0]  write_index,
  input  logic [31:0] write_data,
  pidtc_in_if.sink    sample,
  pidtc_out_if.source result
);

`include "pid_trapezoid_clamped_assert.svh"

  state_t state, state_next;

  logic signed [31:0] gain_p, gain_i, gain_d, upper, lower;
  logic        [31:0] last_time;
  logic signed [32:0] last_error;
  logic signed [63:0] acc;

  logic signed [32:0] err_r;
  logic        [31:0] dt_r;
  logic               bad_r;
  logic signed [31:0] p_r, i_r, d_r, cmd_r;
  logic signed [63:0] hi_lim;
  logic        [63:0] d_prod;

  logic               o_valid, o_bad;
  logic signed [31:0] o_cmd, o_p, o_i, o_d;

  logic               mul_start, mul_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_prod;
  logic               div_start, div_done;
  logic [DIV_N_W-1:0] div_num, div_q;
  logic [DIV_D_W-1:0] div_den;

  logic               accept, bad_in;
  logic signed [33:0] sum_v, de_v;
  logic [33:0]        sum_abs, de_abs, err_abs;
  logic [63:0]        acc_abs, half;
  logic signed [63:0] lo_v, acc_t;

  assign accept  = sample.valid && sample.ready;
  assign bad_in  = sample.timestamp <= last_time;
  assign sum_v   = 34'(last_error) + 34'(err_r);
  assign de_v    = 34'(err_r) - 34'(last_error);
  assign sum_abs = sum_v[33] ? 34'(-sum_v) : 34'(sum_v);
  assign de_abs  = de_v[33] ? 34'(-de_v) : 34'(de_v);
  assign err_abs = err_r[32] ? 34'(-34'(err_r)) : 34'(err_r);
  assign acc_abs = acc[63] ? 64'(-acc) : 64'(acc);
  assign half    = (mul_prod > MUL_P_W'(64'h8000000000000000))
                   ? 64'h4000000000000000 : mul_prod[64:1];
  assign lo_v    = 64'(with_sign(lower[31] ^ gain_i[31], div_q));
  assign acc_t   = (acc > hi_lim) ? hi_lim : ((acc < lo_v) ? lo_v : acc);

  pidtc_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .prod(mul_prod), .done(mul_done)
  );

  pidtc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .quo(div_q), .done(div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next   = state;
    sample.ready = 1'b0;
    mul_start    = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_num      = '0;
    div_den      = '0;
    unique case (state)
      S_IDLE: begin
        sample.ready = 1'b1;
        if (sample.valid) state_next = bad_in ? S_SUM : S_PMUL;
      end
      S_PMUL: begin
        mul_start  = 1'b1;
        mul_a      = mag32(gain_p);
        mul_b      = MUL_B_W'(err_abs);
        state_next = S_PWAIT;
      end
      S_PWAIT: if (mul_done) state_next = (gain_i == '0) ? S_DMUL : S_TMUL;
      S_TMUL: begin
        mul_start  = 1'b1;
        mul_a      = dt_r;
        mul_b      = MUL_B_W'(sum_abs);
        state_next = S_TWAIT;
      end
      S_TWAIT: if (mul_done) state_next = S_HDIV;
      S_HDIV: begin
        div_start  = 1'b1;
        div_num    = DIV_N_W'({mag32(upper), 16'h0000});
        div_den    = mag32(gain_i);
        state_next = S_HWAIT;
      end
      S_HWAIT: if (div_done) state_next = S_LDIV;
      S_LDIV: begin
        div_start  = 1'b1;
        div_num    = DIV_N_W'({mag32(lower), 16'h0000});
        div_den    = mag32(gain_i);
        state_next = S_LWAIT;
      end
      S_LWAIT: if (div_done) state_next = S_IMUL;
      S_IMUL: begin
        mul_start  = 1'b1;
        mul_a      = mag32(gain_i);
        mul_b      = acc_abs[MUL_B_W-1:0];
        state_next = S_IWAIT;
      end
      S_IWAIT: if (mul_done) state_next = S_DMUL;
      S_DMUL: begin
        mul_start  = 1'b1;
        mul_a      = mag32(gain_d);
        mul_b      = MUL_B_W'(de_abs);
        state_next = S_DWAIT;
      end
      S_DWAIT: if (mul_done) state_next = S_DDIV;
      S_DDIV: begin
        div_start  = 1'b1;
        div_num    = d_prod;
        div_den    = dt_r;
        state_next = S_DDWAIT;
      end
      S_DDWAIT: if (div_done) state_next = S_SUM;
      S_SUM: state_next = S_OUT;
      S_OUT: if (!o_valid || result.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p     <= '0;
      gain_i     <= '0;
      gain_d     <= '0;
      upper      <= 32'sh7FFFFFFF;
      lower      <= 32'sh80000000;
      last_time  <= '0;
      last_error <= '0;
      acc        <= '0;
      o_valid    <= 1'b0;
    end else begin
      if (write_en) begin
        unique case (write_index)
          REG_GAIN_P: gain_p <= write_data;
          REG_GAIN_I: gain_i <= write_data;
          REG_GAIN_D: gain_d <= write_data;
          REG_UPPER:  upper  <= write_data;
          REG_LOWER:  lower  <= write_data;
          default: ;
        endcase
      end
      if (accept) last_time <= sample.timestamp;
      if (state == S_PWAIT && mul_done && gain_i == '0) acc <= '0;
      if (state == S_TWAIT && mul_done) begin
        acc <= sum_v[33] ? acc - $signed(half) : acc + $signed(half);
      end
      if (state == S_LWAIT && div_done) acc <= acc_t;
      if (state == S_DDWAIT && div_done) last_error <= err_r;
      if (state == S_OUT && (!o_valid || result.ready)) o_valid <= 1'b1;
      else if (o_valid && result.ready) o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err_r <= 33'(sample.setpoint) - 33'(sample.measured);
      dt_r  <= sample.timestamp - last_time;
      bad_r <= bad_in;
      if (bad_in) begin
        p_r <= '0;
        i_r <= '0;
        d_r <= '0;
      end
    end
    if (state == S_PWAIT && mul_done) begin
      p_r <= clamp_term(with_sign(gain_p[31] ^ err_r[32], mul_prod[79:16]), upper, lower);
      if (gain_i == '0) i_r <= '0;
    end
    if (state == S_HWAIT && div_done) hi_lim <= 64'(with_sign(upper[31] ^ gain_i[31], div_q));
    if (state == S_IWAIT && mul_done) begin
      i_r <= sat32(with_sign(gain_i[31] ^ acc[63], mul_prod[79:16]));
    end
    if (state == S_DWAIT && mul_done) d_prod <= mul_prod[63:0];
    if (state == S_DDWAIT && div_done) begin
      d_r <= clamp_term(with_sign(gain_d[31] ^ de_v[33], {16'h0000, div_q[63:16]}),
                        upper, lower);
    end
    if (state == S_SUM) cmd_r <= sat32(66'(p_r) + 66'(i_r) + 66'(d_r));
    if (state == S_OUT && (!o_valid || result.ready)) begin
      o_cmd <= cmd_r;
      o_p   <= p_r;
      o_i   <= i_r;
      o_d   <= d_r;
      o_bad <= bad_r;
    end
  end

  assign result.valid     = o_valid;
  assign result.command   = o_cmd;
  assign result.p_term    = o_p;
  assign result.i_term    = o_i;
  assign result.d_term    = o_d;
  assign result.ts_reject = o_bad;

  `PIDTC_ASSERT_IMP(a_mul_done_wait, clk, rst, mul_done, state == S_PWAIT || state == S_TWAIT || state == S_IWAIT || state == S_DWAIT)
  `PIDTC_ASSERT_NXT(a_bad_short, clk, rst, accept && bad_in, state == S_SUM && bad_r)
  `PIDTC_ASSERT_IMP(a_bad_zero, clk, rst, result.valid && result.ts_reject, result.command == '0 && result.p_term == '0 && result.i_term == '0 && result.d_term == '0)

endmodule

// File: tb/pidtc_checker.sv
// ----------------------------------------------------------------------------
// PID controller result checker
// Follows the register writes and the sample beats, predicts every result
// with its own wide-integer model of the controller, and compares each result
// beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pidtc_checker
  import pidtc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        write_en,
  input  logic [2:0]  write_index,
  input  logic [31:0] write_data,
  pidtc_in_if         sample,
  pidtc_out_if        result,
  output int          fail_count,
  output int          outstanding
);

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic signed [31:0] command;
    logic signed [31:0] p_term;
    logic signed [31:0] i_term;
    logic signed [31:0] d_term;
    logic               ts_reject;
  } pid_out_t;

  logic signed [31:0] kp, ki, kd, up_lim, lo_lim;
  logic [31:0] prev_ts;
  wide_t prev_err, integ;
  pid_out_t expected_outputs[$];

  function automatic wide_t trunc16(wide_t x);
    return (x < 0) ? -((-x) >>> 16) : (x >>> 16);
  endfunction

  function automatic wide_t clamp_lim(wide_t v);
    if (v > wide_t'(up_lim)) return wide_t'(up_lim);
    if (v < wide_t'(lo_lim)) return wide_t'(lo_lim);
    return v;
  endfunction

  function automatic wide_t sat_word(wide_t v);
    if (v > wide_t'(32'sh7FFFFFFF)) return wide_t'(32'sh7FFFFFFF);
    if (v < wide_t'(32'sh80000000)) return wide_t'(32'sh80000000);
    return v;
  endfunction

  function automatic pid_out_t step_controller(logic signed [31:0] sp,
                                               logic signed [31:0] ms,
                                               logic [31:0] ts);
    pid_out_t r;
    logic [31:0] dt32;
    wide_t dt, err, p, i, d, sum, m, half, hi, lo, de, q, kd_mag, de_mag;
    r = '0;
    if (ts <= prev_ts) begin
      prev_ts = ts;
      r.ts_reject = 1'b1;
      return r;
    end
    dt32 = ts - prev_ts;
    dt = wide_t'({96'd0, dt32});
    prev_ts = ts;
    err = wide_t'(sp) - wide_t'(ms);
    p = clamp_lim(trunc16(wide_t'(kp) * err));
    if (ki != 0) begin
      sum = prev_err + err;
      m = (sum < 0) ? -sum : sum;
      if (m != 0 && dt > (wide_t'(1) <<< 63) / m) half = wide_t'(1) <<< 62;
      else half = (dt * m) >>> 1;
      integ = integ + ((sum < 0) ? -half : half);
      hi = (wide_t'(up_lim) * 65536) / wide_t'(ki);
      lo = (wide_t'(lo_lim) * 65536) / wide_t'(ki);
      if (integ > hi) integ = hi;
      else if (integ < lo) integ = lo;
      i = sat_word(trunc16(wide_t'(ki) * integ));
    end else begin
      integ = 0;
      i = 0;
    end
    de = err - prev_err;
    kd_mag = (kd < 0) ? -wide_t'(kd) : wide_t'(kd);
    de_mag = (de < 0) ? -de : de;
    q = (kd_mag * de_mag) / dt;
    d = clamp_lim(((kd < 0) != (de < 0)) ? -(q >>> 16) : (q >>> 16));
    prev_err = err;
    r.command = 32'(sat_word(p + i + d));
    r.p_term = 32'(p);
    r.i_term = 32'(i);
    r.d_term = 32'(d);
    return r;
  endfunction

  always @(posedge clk) begin
    pid_out_t want;
    if (rst) begin
      kp = 0;
      ki = 0;
      kd = 0;
      up_lim = 32'sh7FFFFFFF;
      lo_lim = 32'sh80000000;
      prev_ts = 0;
      prev_err = 0;
      integ = 0;
      expected_outputs.delete();
      fail_count = 0;
    end else begin
      if (write_en) begin
        case (cfg_reg_t'(write_index))
          REG_GAIN_P: kp = write_data;
          REG_GAIN_I: ki = write_data;
          REG_GAIN_D: kd = write_data;
          REG_UPPER:  up_lim = write_data;
          REG_LOWER:  lo_lim = write_data;
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (expected_outputs.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %h", $realtime,
                   {result.command, result.p_term, result.i_term, result.d_term,
                    result.ts_reject});
          fail_count++;
        end else begin
          want = expected_outputs.pop_front();
          if (want.command !== result.command || want.p_term !== result.p_term ||
              want.i_term !== result.i_term || want.d_term !== result.d_term ||
              want.ts_reject !== result.ts_reject) begin
            $display("%0t: mismatch expected cmd %h p %h i %h d %h bad %b", $realtime,
                     want.command, want.p_term, want.i_term, want.d_term, want.ts_reject);
            $display("%0t:            actual cmd %h p %h i %h d %h bad %b", $realtime,
                     result.command, result.p_term, result.i_term, result.d_term,
                     result.ts_reject);
            fail_count++;
          end
        end
      end
      if (sample.valid && sample.ready)
        expected_outputs.push_back(step_controller(sample.setpoint, sample.measured,
                                                   sample.timestamp));
    end
    outstanding = expected_outputs.size();
  end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// PID controller testbench
// Drives configuration phases and timestamped samples, directed corner cases
// first and then random control-loop traffic, with random idling on both
// channels and one long result hold-off; the checker gives the verdict data.
// ----------------------------------------------------------------------------
module testbench;
  import pidtc_pkg::*;

  logic        clk;
  logic        rst;
  logic        write_en;
  logic [2:0]  write_index;
  logic [31:0] write_data;
  int          fail_count;
  int          outstanding;
  int          quiet_cycles;
  logic        calm;
  logic        hold_req;
  logic [31:0] now_ticks;

  pidtc_in_if  sample();
  pidtc_out_if result();

  pid_trapezoid_clamped u_dut (
    .clk(clk), .rst(rst), .write_en(write_en), .write_index(write_index),
    .write_data(write_data), .sample(sample), .result(result)
  );

  pidtc_checker u_checker (
    .clk(clk), .rst(rst), .write_en(write_en), .write_index(write_index),
    .write_data(write_data), .sample(sample), .result(result),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (sample.valid && sample.ready) || (result.valid && result.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    result.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req && !calm) begin
        result.ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        result.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        result.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_sample(logic [31:0] sp, logic [31:0] ms, logic [31:0] ts);
    sample.valid <= 1'b1;
    sample.setpoint <= sp;
    sample.measured <= ms;
    sample.timestamp <= ts;
    do @(posedge clk); while (!(sample.valid && sample.ready));
    now_ticks = ts;
    if (!calm && $urandom_range(0, 3) == 0) begin
      sample.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic set_gains(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                           logic [31:0] hi, logic [31:0] lo);
    sample.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    write_en <= 1'b1;
    write_index <= REG_GAIN_P; write_data <= kp; @(posedge clk);
    write_index <= REG_GAIN_I; write_data <= ki; @(posedge clk);
    write_index <= REG_GAIN_D; write_data <= kd; @(posedge clk);
    write_index <= REG_UPPER;  write_data <= hi; @(posedge clk);
    write_index <= REG_LOWER;  write_data <= lo; @(posedge clk);
    write_en <= 1'b0;
  endtask

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h0;
      2: return 32'h7FFFFFFF;
      3: return 32'h80000000;
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  task automatic random_samples(int count);
    int r;
    logic [31:0] ts;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 6) ts = now_ticks - $urandom_range(0, 3);
      else if (r < 8) ts = $urandom;
      else if (r < 10) ts = now_ticks + $urandom_range(1, 32'h7FFFFFFF);
      else ts = now_ticks + $urandom_range(1, 300);
      send_sample(pick_value(), pick_value(), ts);
    end
  endtask

  initial begin
    rst = 1'b1;
    calm = 1'b0;
    hold_req = 1'b0;
    now_ticks = 0;
    write_en = 1'b0;
    write_index = REG_GAIN_P;
    write_data = 0;
    sample.valid = 1'b0;
    sample.setpoint = 0;
    sample.measured = 0;
    sample.timestamp = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_sample(32'h0001_0000, 32'h0, 32'h0);
    send_sample(32'h7FFFFFFF, 32'h80000000, 32'h1);
    set_gains(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0064_0000, 32'hFF9C_0000);
    send_sample(32'h0, 32'h0, 32'h0);
    send_sample(32'h7FFFFFFF, 32'h80000000, 32'h1);
    send_sample(32'h80000000, 32'h7FFFFFFF, 32'h2);
    send_sample(32'h0003_0000, 32'h0001_0000, 32'h2);
    send_sample(32'h0003_0000, 32'h0001_0000, 32'h1);
    send_sample(32'h0, 32'h0, 32'h3);
    send_sample(32'h0005_0000, 32'hFFFB_0000, 32'hFFFFFFFF);
    send_sample(32'h0005_0000, 32'h0, 32'hFFFFFFFF);
    send_sample(32'h0, 32'h0, 32'h5);
    set_gains(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    send_sample(32'h7FFFFFFF, 32'h80000000, 32'h6);
    send_sample(32'h80000000, 32'h7FFFFFFF, 32'h7);
    send_sample(32'h7FFFFFFF, 32'h80000000, 32'h8000_0007);
    send_sample(32'h0, 32'h1, 32'h8000_0008);
    set_gains(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFB_0000, 32'h0005_0000);
    send_sample(32'h7FFFFFFF, 32'h80000000, 32'h0000_0010);
    send_sample(32'h80000000, 32'h0, 32'h0000_0011);
    send_sample(32'h1234_5678, 32'h8765_4321, 32'h0000_0100);
    set_gains(32'h0002_0000, 32'h0, 32'hFFFF_0000, 32'h0010_0000, 32'hFFF0_0000);
    send_sample(32'h0004_0000, 32'h0, 32'h0000_0200);
    send_sample(32'h0, 32'h0004_0000, 32'h0000_0201);

    for (int ph = 0; ph < 8; ph++) begin
      set_gains(pick_gain(), pick_gain(), pick_gain(),
                (ph == 0) ? 32'h7FFFFFFF : $urandom,
                (ph == 0) ? 32'h80000000 : $urandom);
      if (ph == 2) hold_req = 1'b1;
      if (ph == 7) calm = 1'b1;
      random_samples(150);
    end

    sample.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

// File: pid_trapezoid_clamped.f
+incdir+rtl
rtl/pidtc_pkg.sv
rtl/pidtc_if.sv
rtl/pidtc_mul.sv
rtl/pidtc_div.sv
rtl/pid_trapezoid_clamped.sv
tb/pidtc_checker.sv
tb/testbench.sv
